>>> rtl/rosi_pkg.sv
// shared constants for the ray versus oriented box slab intersector
// no dependencies; used by the interfaces, the arithmetic units and the top level
package rosi_pkg;

  // field formats
  localparam int POS_W     = 20;  // signed positions and directions, 8 fraction bits
  localparam int AXIS_W    = 16;  // signed axis, unit direction and normal components
  localparam int AXIS_FRAC = AXIS_W - 2;
  localparam int DIST_W    = POS_W - 1;
  localparam int LEN_EXTRA = 10;

  // square root unit
  localparam int LEN2_W   = 2 * POS_W;
  localparam int RAD_W    = LEN2_W + 2 * LEN_EXTRA;
  localparam int ROOT_W   = RAD_W / 2;
  localparam int SQRT_LAT = ROOT_W;

  // divider unit
  localparam int DNUM_W  = 54;
  localparam int DDEN_W  = 34;
  localparam int DQ_W    = 21;
  localparam int DIV_LAT = DQ_W + 1;

  // slab arithmetic
  localparam int E_W     = 39;
  localparam int F_W     = 34;
  localparam int A_W     = E_W + 1;
  localparam int T_W     = 22;
  localparam int T_CLAMP = 1 << (T_W - 2);

  // configuration port
  localparam int CFG_AW      = 6;
  localparam int CFG_DW      = 64;
  localparam int CFG_IDX_LSB = 3;

  localparam logic [2:0] REG_CENTER  = 3'd0;
  localparam logic [2:0] REG_HALF    = 3'd1;
  localparam logic [2:0] REG_RIGHT   = 3'd2;
  localparam logic [2:0] REG_UP      = 3'd3;
  localparam logic [2:0] REG_FORWARD = 3'd4;

endpackage

>>> rtl/rosi_if.sv
// valid/ready channels for rays in and intersection results out
// depends on rosi_pkg for the field widths
interface rosi_ray_if import rosi_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [POS_W-1:0]  origin_x;
  logic signed [POS_W-1:0]  origin_y;
  logic signed [POS_W-1:0]  origin_z;
  logic signed [POS_W-1:0]  dir_x;
  logic signed [POS_W-1:0]  dir_y;
  logic signed [POS_W-1:0]  dir_z;
  logic        [DIST_W-1:0] max_distance;

  modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                  max_distance, input ready);
  modport sink   (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                  max_distance, output ready);
endinterface

interface rosi_res_if import rosi_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     hit_flag;
  logic        [DIST_W-1:0] hit_distance;
  logic signed [POS_W-1:0]  point_x;
  logic signed [POS_W-1:0]  point_y;
  logic signed [POS_W-1:0]  point_z;
  logic signed [AXIS_W-1:0] normal_x;
  logic signed [AXIS_W-1:0] normal_y;
  logic signed [AXIS_W-1:0] normal_z;

  modport source (output valid, hit_flag, hit_distance, point_x, point_y, point_z,
                  normal_x, normal_y, normal_z, input ready);
  modport sink   (input valid, hit_flag, hit_distance, point_x, point_y, point_z,
                  normal_x, normal_y, normal_z, output ready);
endinterface

>>> rtl/rosi_sqrt.sv
// pipelined floor square root, one result bit per stage
// depends on rosi_pkg for the radicand and root widths
module rosi_sqrt import rosi_pkg::*; (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [RAD_W-1:0]  rad_i,
  output logic [ROOT_W-1:0] root_o
);

  logic [RAD_W-1:0] x_q [SQRT_LAT];
  logic [RAD_W-1:0] r_q [SQRT_LAT];

  for (genvar s = 0; s < SQRT_LAT; s++) begin : g_stage
    localparam logic [RAD_W-1:0] BitVal = RAD_W'(1) << (2 * (SQRT_LAT - 1 - s));
    logic [RAD_W-1:0] x_in, r_in, trial, x_d, r_d;

    if (s == 0) begin : g_first
      assign x_in = rad_i;
      assign r_in = '0;
    end else begin : g_next
      assign x_in = x_q[s-1];
      assign r_in = r_q[s-1];
    end

    assign trial = r_in + BitVal;

    always_comb begin
      if (x_in >= trial) begin
        x_d = x_in - trial;
        r_d = (r_in >> 1) + BitVal;
      end else begin
        x_d = x_in;
        r_d = r_in >> 1;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[s] <= x_d;
        r_q[s] <= r_d;
      end
    end
  end

  assign root_o = r_q[SQRT_LAT-1][ROOT_W-1:0];

endmodule

>>> rtl/rosi_div.sv
// pipelined unsigned restoring divider with an overflow flag for large quotients
// depends on rosi_pkg for operand widths and latency
module rosi_div import rosi_pkg::*; (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [DNUM_W-1:0] num_i,
  input  logic [DDEN_W-1:0] den_i,
  output logic [DQ_W-1:0]   quo_o,
  output logic              ovf_o
);

  localparam int W = DDEN_W + DQ_W;

  logic [DNUM_W-1:0] rem_q [DIV_LAT];
  logic [DDEN_W-1:0] den_q [DIV_LAT];
  logic [DQ_W-1:0]   quo_q [DIV_LAT];
  logic              ovf_q [DIV_LAT];

  // quotient does not fit (or divisor is zero)
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= num_i;
      den_q[0] <= den_i;
      quo_q[0] <= '0;
      ovf_q[0] <= W'(num_i) >= (W'(den_i) << DQ_W);
    end
  end

  for (genvar k = 1; k < DIV_LAT; k++) begin : g_stage
    localparam int J = DQ_W - k;
    logic [W-1:0]      sub;
    logic              take;
    logic [DNUM_W-1:0] rem_d;

    assign sub   = W'(den_q[k-1]) << J;
    assign take  = W'(rem_q[k-1]) >= sub;
    assign rem_d = take ? DNUM_W'(W'(rem_q[k-1]) - sub) : rem_q[k-1];

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= rem_d;
        den_q[k] <= den_q[k-1];
        quo_q[k] <= quo_q[k-1] | (DQ_W'(take) << J);
        ovf_q[k] <= ovf_q[k-1];
      end
    end
  end

  assign quo_o = quo_q[DIV_LAT-1];
  assign ovf_o = ovf_q[DIV_LAT-1];

endmodule

>>> rtl/ray_obb_slab_intersect_top.sv
// ray versus oriented box intersector: one ray per cycle sustained while results are taken
// most of the pipeline lies in the 30-stage square root and two 22-stage dividers in series
// the whole pipeline advances whenever the output register is empty or being taken
// reset (rst_ni low, asynchronous) clears the box registers and all valid bits
// depends on rosi_pkg, rosi_if, rosi_sqrt and rosi_div
module ray_obb_slab_intersect_top import rosi_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  rosi_ray_if.sink          ray_i,
  rosi_res_if.source        res_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  localparam int LAT = 13 + SQRT_LAT + 2 * DIV_LAT;
  localparam int PS_W = AXIS_W + T_W;
  localparam int S_W  = POS_W + 6;

  typedef logic signed [POS_W-1:0]  pos_t;
  typedef logic signed [AXIS_W-1:0] axc_t;
  typedef logic signed [T_W-1:0]    t_t;

  typedef struct packed {
    pos_t [2:0]              o;
    logic [2:0][POS_W-1:0]   m;
    logic [2:0]              neg;
    logic [DIST_W-1:0]       maxd;
  } sb1_t;

  typedef struct packed {
    pos_t [2:0]        o;
    axc_t [2:0]        u;
    logic [2:0]        par;
    logic [2:0]        pmiss;
    logic [2:0]        fpos;
    logic [2:0][1:0]   tneg;
    logic [DIST_W-1:0] maxd;
  } sb2_t;

  typedef struct packed {
    t_t [2:0] lo;
    t_t [2:0] hi;
    sb2_t     sb;
  } sb3_t;

  typedef struct packed {
    t_t         tmin;
    t_t         tmax;
    axc_t [2:0] nrm;
    logic       miss;
  } slab_t;

  function automatic axc_t neg_sat(input axc_t a);
    axc_t r;
    if (a == {1'b1, {(AXIS_W-1){1'b0}}}) r = {1'b0, {(AXIS_W-1){1'b1}}};
    else r = -a;
    return r;
  endfunction

  // ---------------------------------------------------------------- config
  logic [3*POS_W-1:0]  center_q, half_q;
  logic [3*AXIS_W-1:0] axis_q [3];
  logic [2:0]          cfg_idx;
  logic                cfg_wr;
  pos_t                cen  [3];
  logic [POS_W-1:0]    half [3];
  axc_t                axv  [3][3];

  assign cfg_idx = paddr[CFG_AW-1:CFG_IDX_LSB];
  assign cfg_wr  = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_q <= '0;
      half_q   <= '0;
      for (int k = 0; k < 3; k++) axis_q[k] <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_CENTER:  center_q  <= pwdata[3*POS_W-1:0];
        REG_HALF:    half_q    <= pwdata[3*POS_W-1:0];
        REG_RIGHT:   axis_q[0] <= pwdata[3*AXIS_W-1:0];
        REG_UP:      axis_q[1] <= pwdata[3*AXIS_W-1:0];
        REG_FORWARD: axis_q[2] <= pwdata[3*AXIS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_CENTER:  prdata = CFG_DW'(center_q);
      REG_HALF:    prdata = CFG_DW'(half_q);
      REG_RIGHT:   prdata = CFG_DW'(axis_q[0]);
      REG_UP:      prdata = CFG_DW'(axis_q[1]);
      REG_FORWARD: prdata = CFG_DW'(axis_q[2]);
      default:     prdata = '0;
    endcase
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cen[i]  = center_q[i*POS_W +: POS_W];
      half[i] = half_q[i*POS_W +: POS_W];
      for (int k = 0; k < 3; k++) axv[k][i] = axis_q[k][i*AXIS_W +: AXIS_W];
    end
  end

  // ---------------------------------------------------------------- flow
  logic           en;
  logic [LAT-1:0] vld_q;

  assign en          = !vld_q[LAT-1] || res_o.ready;
  assign ray_i.ready = en;
  assign res_o.valid = vld_q[LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], ray_i.valid};
    end
  end

  // ---------------------------------------------------------------- squares
  pos_t               o_in [3];
  pos_t               d_in [3];
  pos_t               s1_o_q [3];
  logic [POS_W-1:0]   s1_m_q [3];
  logic [2:0]         s1_neg_q;
  logic [LEN2_W-1:0]  s1_sq_q [3];
  logic [DIST_W-1:0]  s1_maxd_q;

  always_comb begin
    o_in[0] = ray_i.origin_x;
    o_in[1] = ray_i.origin_y;
    o_in[2] = ray_i.origin_z;
    d_in[0] = ray_i.dir_x;
    d_in[1] = ray_i.dir_y;
    d_in[2] = ray_i.dir_z;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s1_o_q[i]   <= o_in[i];
        s1_neg_q[i] <= d_in[i][POS_W-1];
        s1_m_q[i]   <= d_in[i][POS_W-1] ? -d_in[i] : d_in[i];
        s1_sq_q[i]  <= d_in[i] * d_in[i];
      end
      s1_maxd_q <= ray_i.max_distance;
    end
  end

  logic [LEN2_W-1:0] s2_len2_q;
  sb1_t              s2_sb_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_len2_q <= s1_sq_q[0] + s1_sq_q[1] + s1_sq_q[2];
      for (int i = 0; i < 3; i++) begin
        s2_sb_q.o[i]   <= s1_o_q[i];
        s2_sb_q.m[i]   <= s1_m_q[i];
        s2_sb_q.neg[i] <= s1_neg_q[i];
      end
      s2_sb_q.maxd <= s1_maxd_q;
    end
  end

  // ---------------------------------------------------------------- length
  logic [ROOT_W-1:0] root;
  sb1_t              sq_sb_q [SQRT_LAT];

  rosi_sqrt u_sqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  ({s2_len2_q, {(2*LEN_EXTRA){1'b0}}}),
    .root_o (root)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      sq_sb_q[0] <= s2_sb_q;
      for (int s = 1; s < SQRT_LAT; s++) sq_sb_q[s] <= sq_sb_q[s-1];
    end
  end

  logic [DNUM_W-1:0] s4_num_q [3];
  logic [DDEN_W-1:0] s4_den_q;
  sb1_t              s4_sb_q;

  // rounded quotient: add half the divisor before dividing
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s4_num_q[i] <= (DNUM_W'(sq_sb_q[SQRT_LAT-1].m[i]) << (AXIS_FRAC + LEN_EXTRA))
                     + DNUM_W'(root >> 1);
      end
      s4_den_q <= DDEN_W'(root);
      s4_sb_q  <= sq_sb_q[SQRT_LAT-1];
    end
  end

  // ---------------------------------------------------------------- normalize
  logic [DQ_W-1:0] uq   [3];
  logic            uovf [3];
  sb1_t            ud_sb_q [DIV_LAT];

  for (genvar i = 0; i < 3; i++) begin : g_udiv
    rosi_div u_div (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (s4_num_q[i]),
      .den_i (s4_den_q),
      .quo_o (uq[i]),
      .ovf_o (uovf[i])
    );
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ud_sb_q[0] <= s4_sb_q;
      for (int s = 1; s < DIV_LAT; s++) ud_sb_q[s] <= ud_sb_q[s-1];
    end
  end

  axc_t                    s5_u_q [3];
  logic signed [POS_W:0]   s5_delta_q [3];
  pos_t                    s5_o_q [3];
  logic [DIST_W-1:0]       s5_maxd_q;

  // a zero-length direction shows up as a divider overflow and gives u = 0
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        if (uovf[i]) s5_u_q[i] <= '0;
        else if (ud_sb_q[DIV_LAT-1].neg[i]) s5_u_q[i] <= -axc_t'(uq[i][AXIS_W-1:0]);
        else s5_u_q[i] <= axc_t'(uq[i][AXIS_W-1:0]);
        s5_delta_q[i] <= (POS_W+1)'(cen[i]) - (POS_W+1)'(ud_sb_q[DIV_LAT-1].o[i]);
        s5_o_q[i]     <= ud_sb_q[DIV_LAT-1].o[i];
      end
      s5_maxd_q <= ud_sb_q[DIV_LAT-1].maxd;
    end
  end

  // ---------------------------------------------------------------- projections
  logic signed [2*AXIS_W-1:0]   s6_fp_q [3][3];
  logic signed [AXIS_W+POS_W:0] s6_ep_q [3][3];
  axc_t                         s6_u_q [3];
  pos_t                         s6_o_q [3];
  logic [DIST_W-1:0]            s6_maxd_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        for (int i = 0; i < 3; i++) begin
          s6_fp_q[k][i] <= s5_u_q[i] * axv[k][i];
          s6_ep_q[k][i] <= axv[k][i] * s5_delta_q[i];
        end
      end
      for (int i = 0; i < 3; i++) begin
        s6_u_q[i] <= s5_u_q[i];
        s6_o_q[i] <= s5_o_q[i];
      end
      s6_maxd_q <= s5_maxd_q;
    end
  end

  logic signed [F_W-1:0] s7_f_q [3];
  logic signed [E_W-1:0] s7_e_q [3];
  axc_t                  s7_u_q [3];
  pos_t                  s7_o_q [3];
  logic [DIST_W-1:0]     s7_maxd_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        s7_f_q[k] <= F_W'(s6_fp_q[k][0]) + F_W'(s6_fp_q[k][1]) + F_W'(s6_fp_q[k][2]);
        s7_e_q[k] <= E_W'(s6_ep_q[k][0]) + E_W'(s6_ep_q[k][1]) + E_W'(s6_ep_q[k][2]);
      end
      for (int i = 0; i < 3; i++) begin
        s7_u_q[i] <= s6_u_q[i];
        s7_o_q[i] <= s6_o_q[i];
      end
      s7_maxd_q <= s6_maxd_q;
    end
  end

  // ---------------------------------------------------------------- slab bounds
  logic [DNUM_W-1:0] s8_num_d [3][2];
  logic [DDEN_W-1:0] s8_den_d [3];
  sb2_t              s8_sb_d;
  logic [DNUM_W-1:0] s8_num_q [3][2];
  logic [DDEN_W-1:0] s8_den_q [3];
  sb2_t              s8_sb_q;

  always_comb begin
    logic signed [A_W-1:0] h, e, a1, a2;
    logic        [A_W-1:0] m1, m2;
    logic                  fneg;
    for (int i = 0; i < 3; i++) begin
      s8_sb_d.o[i] = s7_o_q[i];
      s8_sb_d.u[i] = s7_u_q[i];
    end
    s8_sb_d.maxd = s7_maxd_q;
    for (int k = 0; k < 3; k++) begin
      h    = signed'({{(A_W-AXIS_FRAC-POS_W){1'b0}}, half[k], {AXIS_FRAC{1'b0}}});
      e    = A_W'(s7_e_q[k]);
      a1   = e + h;
      a2   = e - h;
      m1   = a1[A_W-1] ? -a1 : a1;
      m2   = a2[A_W-1] ? -a2 : a2;
      fneg = s7_f_q[k][F_W-1];
      s8_num_d[k][0]     = DNUM_W'(m1) << AXIS_FRAC;
      s8_num_d[k][1]     = DNUM_W'(m2) << AXIS_FRAC;
      s8_den_d[k]        = fneg ? -s7_f_q[k] : s7_f_q[k];
      s8_sb_d.tneg[k][0] = a1[A_W-1] ^ fneg;
      s8_sb_d.tneg[k][1] = a2[A_W-1] ^ fneg;
      s8_sb_d.par[k]     = s7_f_q[k] == '0;
      s8_sb_d.pmiss[k]   = (e < -h) || (e > h);
      s8_sb_d.fpos[k]    = !fneg && (s7_f_q[k] != '0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        s8_num_q[k][0] <= s8_num_d[k][0];
        s8_num_q[k][1] <= s8_num_d[k][1];
        s8_den_q[k]    <= s8_den_d[k];
      end
      s8_sb_q <= s8_sb_d;
    end
  end

  logic [DQ_W-1:0] tq   [3][2];
  logic            tovf [3][2];
  sb2_t            sd_sb_q [DIV_LAT];

  for (genvar k = 0; k < 3; k++) begin : g_tdiv
    for (genvar j = 0; j < 2; j++) begin : g_side
      rosi_div u_div (
        .clk_i (clk_i),
        .en_i  (en),
        .num_i (s8_num_q[k][j]),
        .den_i (s8_den_q[k]),
        .quo_o (tq[k][j]),
        .ovf_o (tovf[k][j])
      );
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sd_sb_q[0] <= s8_sb_q;
      for (int s = 1; s < DIV_LAT; s++) sd_sb_q[s] <= sd_sb_q[s-1];
    end
  end

  // bounds beyond the clamp compare the same way as the exact values would
  sb3_t s9_sb_d, s9_sb_q;

  always_comb begin
    t_t t [2];
    t_t tm;
    s9_sb_d.sb = sd_sb_q[DIV_LAT-1];
    for (int k = 0; k < 3; k++) begin
      for (int j = 0; j < 2; j++) begin
        if (tovf[k][j] || (tq[k][j] > DQ_W'(T_CLAMP))) tm = T_W'(T_CLAMP);
        else tm = T_W'(tq[k][j]);
        t[j] = sd_sb_q[DIV_LAT-1].tneg[k][j] ? -tm : tm;
      end
      if (t[0] > t[1]) begin
        s9_sb_d.lo[k] = t[1];
        s9_sb_d.hi[k] = t[0];
      end else begin
        s9_sb_d.lo[k] = t[0];
        s9_sb_d.hi[k] = t[1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) s9_sb_q <= s9_sb_d;
  end

  // ---------------------------------------------------------------- slab clipping
  slab_t sl_q  [3];
  sb3_t  sb3_q [3];

  for (genvar k = 0; k < 3; k++) begin : g_slab
    slab_t st_in, st_d;
    sb3_t  sb_in;

    if (k == 0) begin : g_first
      assign st_in = '{tmin: '0, tmax: T_W'(s9_sb_q.sb.maxd), nrm: '0, miss: 1'b0};
      assign sb_in = s9_sb_q;
    end else begin : g_next
      assign st_in = sl_q[k-1];
      assign sb_in = sb3_q[k-1];
    end

    always_comb begin
      st_d = st_in;
      if (!st_in.miss) begin
        if (!sb_in.sb.par[k]) begin
          if (sb_in.lo[k] > st_in.tmin) begin
            st_d.tmin = sb_in.lo[k];
            for (int i = 0; i < 3; i++) begin
              st_d.nrm[i] = sb_in.sb.fpos[k] ? neg_sat(axv[k][i]) : axv[k][i];
            end
          end
          if (sb_in.hi[k] < st_in.tmax) st_d.tmax = sb_in.hi[k];
          if (st_d.tmin > st_d.tmax) st_d.miss = 1'b1;
        end else if (sb_in.sb.pmiss[k]) begin
          st_d.miss = 1'b1;
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        sl_q[k]  <= st_d;
        sb3_q[k] <= sb_in;
      end
    end
  end

  // ---------------------------------------------------------------- hit point
  logic signed [PS_W-1:0] s13_prod_q [3];
  slab_t                  s13_st_q;
  pos_t                   s13_o_q [3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s13_prod_q[i] <= sb3_q[2].sb.u[i] * sl_q[2].tmin;
        s13_o_q[i]    <= sb3_q[2].sb.o[i];
      end
      s13_st_q <= sl_q[2];
    end
  end

  logic              out_hit_q;
  logic [DIST_W-1:0] out_dist_q;
  pos_t              out_pt_q [3];
  axc_t              out_nrm_q [3];
  pos_t              pt_d [3];

  // round to nearest with ties away from zero, then saturate
  always_comb begin
    logic        [PS_W-1:0] mag;
    logic        [PS_W-1:0] rnd;
    logic signed [S_W-1:0]  rs, sum;
    for (int i = 0; i < 3; i++) begin
      mag = s13_prod_q[i][PS_W-1] ? -s13_prod_q[i] : s13_prod_q[i];
      rnd = (mag + (PS_W'(1) << (AXIS_FRAC - 1))) >> AXIS_FRAC;
      rs  = s13_prod_q[i][PS_W-1] ? -S_W'(rnd) : S_W'(rnd);
      sum = S_W'(s13_o_q[i]) + rs;
      if (sum > S_W'(signed'({1'b0, {(POS_W-1){1'b1}}})))
        pt_d[i] = {1'b0, {(POS_W-1){1'b1}}};
      else if (sum < S_W'(signed'({1'b1, {(POS_W-1){1'b0}}})))
        pt_d[i] = {1'b1, {(POS_W-1){1'b0}}};
      else pt_d[i] = sum[POS_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_hit_q <= !s13_st_q.miss;
      if (s13_st_q.miss) out_dist_q <= '0;
      else if (s13_st_q.tmin > T_W'({DIST_W{1'b1}})) out_dist_q <= '1;
      else out_dist_q <= s13_st_q.tmin[DIST_W-1:0];
      for (int i = 0; i < 3; i++) begin
        out_pt_q[i]  <= s13_st_q.miss ? '0 : pt_d[i];
        out_nrm_q[i] <= s13_st_q.miss ? '0 : s13_st_q.nrm[i];
      end
    end
  end

  assign res_o.hit_flag     = out_hit_q;
  assign res_o.hit_distance = out_dist_q;
  assign res_o.point_x      = out_pt_q[0];
  assign res_o.point_y      = out_pt_q[1];
  assign res_o.point_z      = out_pt_q[2];
  assign res_o.normal_x     = out_nrm_q[0];
  assign res_o.normal_y     = out_nrm_q[1];
  assign res_o.normal_z     = out_nrm_q[2];

`ifndef SYNTHESIS
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && !res_o.hit_flag |-> res_o.hit_distance == '0 &&
      res_o.normal_x == '0 && res_o.normal_y == '0 && res_o.normal_z == '0)
    else $error("miss result carries nonzero fields");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld_q))
    else $error("valid line moved during a stall");

  a_zero_dist_normal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.hit_flag && res_o.hit_distance == '0 |->
      res_o.normal_x == '0 && res_o.normal_y == '0 && res_o.normal_z == '0)
    else $error("hit at distance zero has an entry face");
`endif

endmodule

>>> verif/ray_obb_slab_intersect_top_tb.sv
// testbench for the ray versus oriented box slab intersector
// predicts every result in a scoreboard class and checks the results in order
// depends on rosi_pkg, rosi_if and the ray_obb_slab_intersect_top rtl
module ray_obb_slab_intersect_top_tb;
  import rosi_pkg::*;

  typedef struct packed {
    logic signed [POS_W-1:0] ox, oy, oz;
    logic signed [POS_W-1:0] dx, dy, dz;
    logic [DIST_W-1:0]       max_dist;
  } ray_t;

  typedef struct packed {
    logic                     hit;
    logic [DIST_W-1:0]        hit_dist;
    logic signed [POS_W-1:0]  px, py, pz;
    logic signed [AXIS_W-1:0] nx, ny, nz;
  } hit_t;

  localparam int RAY_W = $bits(ray_t);

  class hit_scoreboard;
    logic [CFG_DW-1:0] box_reg [5];
    hit_t              expected_hits [$];
    int                errors;

    function new();
      foreach (box_reg[i]) box_reg[i] = '0;
      errors = 0;
    endfunction

    function longint unsigned root_floor(longint unsigned x);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
        if (x >= r + b) begin
          x = x - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    // rounding to nearest, ties away from zero
    function longint round_q(longint v);
      longint m;
      m = (v < 0) ? -v : v;
      m = (m + (64'sd1 << (AXIS_FRAC - 1))) >>> AXIS_FRAC;
      return (v < 0) ? -m : m;
    endfunction

    function longint sat_val(longint v, int w);
      longint hi, lo;
      hi = (64'sd1 <<< (w - 1)) - 1;
      lo = -hi - 1;
      return (v > hi) ? hi : ((v < lo) ? lo : v);
    endfunction

    function hit_t trace_ray(ray_t r);
      longint o [3], d [3], u [3], ax [3][3], delta [3], nrm [3];
      longint tmin, tmax, e, f, h, t1, t2, tmp, p;
      longint unsigned len2, len, m;
      hit_t res;
      res = '0;
      o[0] = r.ox; o[1] = r.oy; o[2] = r.oz;
      d[0] = r.dx; d[1] = r.dy; d[2] = r.dz;
      len2 = 0;
      for (int i = 0; i < 3; i++) begin
        len2 += d[i] * d[i];
        delta[i] = longint'($signed(box_reg[REG_CENTER][i*POS_W +: POS_W])) - o[i];
        for (int k = 0; k < 3; k++)
          ax[k][i] = longint'($signed(box_reg[REG_RIGHT + k][i*AXIS_W +: AXIS_W]));
        nrm[i] = 0;
      end
      tmin = 0;
      tmax = r.max_dist;
      len = root_floor(len2 << (2 * LEN_EXTRA));
      for (int i = 0; i < 3; i++) begin
        if (len == 0) begin
          u[i] = 0;
        end else begin
          m = (d[i] < 0) ? -d[i] : d[i];
          m = ((m << (AXIS_FRAC + LEN_EXTRA)) + len / 2) / len;
          u[i] = (d[i] < 0) ? -longint'(m) : longint'(m);
        end
      end
      for (int k = 0; k < 3; k++) begin
        h = longint'(box_reg[REG_HALF][k*POS_W +: POS_W]) <<< AXIS_FRAC;
        e = 0;
        f = 0;
        for (int i = 0; i < 3; i++) begin
          e += ax[k][i] * delta[i];
          f += u[i] * ax[k][i];
        end
        if (f != 0) begin
          t1 = ((e + h) * (64'sd1 <<< AXIS_FRAC)) / f;
          t2 = ((e - h) * (64'sd1 <<< AXIS_FRAC)) / f;
          if (t1 > t2) begin
            tmp = t1; t1 = t2; t2 = tmp;
          end
          if (t1 > tmin) begin
            tmin = t1;
            for (int i = 0; i < 3; i++)
              nrm[i] = sat_val((f > 0) ? -ax[k][i] : ax[k][i], AXIS_W);
          end
          if (t2 < tmax) tmax = t2;
          if (tmin > tmax) return '0;
        end else if (e < -h || e > h) begin
          return '0;
        end
      end
      res.hit      = 1'b1;
      res.hit_dist = (tmin > (64'sd1 <<< DIST_W) - 1) ? '1 : tmin[DIST_W-1:0];
      p = sat_val(o[0] + round_q(u[0] * tmin), POS_W); res.px = p[POS_W-1:0];
      p = sat_val(o[1] + round_q(u[1] * tmin), POS_W); res.py = p[POS_W-1:0];
      p = sat_val(o[2] + round_q(u[2] * tmin), POS_W); res.pz = p[POS_W-1:0];
      res.nx = nrm[0][AXIS_W-1:0];
      res.ny = nrm[1][AXIS_W-1:0];
      res.nz = nrm[2][AXIS_W-1:0];
      return res;
    endfunction

    function void note_ray(ray_t r);
      expected_hits.push_back(trace_ray(r));
    endfunction

    task report(string what);
      $display("mismatch at %0t: %s", $time, what);
      errors++;
    endtask

    task check_hit(hit_t got);
      hit_t exp_hit;
      if (expected_hits.size() == 0) begin
        report("result with nothing expected");
        return;
      end
      exp_hit = expected_hits.pop_front();
      if (got.hit !== exp_hit.hit)
        report($sformatf("hit_flag got %0d exp %0d", got.hit, exp_hit.hit));
      if (got.hit_dist !== exp_hit.hit_dist)
        report($sformatf("hit_distance got %0d exp %0d", got.hit_dist, exp_hit.hit_dist));
      if (got.px !== exp_hit.px) report($sformatf("point_x got %0d exp %0d", got.px, exp_hit.px));
      if (got.py !== exp_hit.py) report($sformatf("point_y got %0d exp %0d", got.py, exp_hit.py));
      if (got.pz !== exp_hit.pz) report($sformatf("point_z got %0d exp %0d", got.pz, exp_hit.pz));
      if (got.nx !== exp_hit.nx) report($sformatf("normal_x got %0d exp %0d", got.nx, exp_hit.nx));
      if (got.ny !== exp_hit.ny) report($sformatf("normal_y got %0d exp %0d", got.ny, exp_hit.ny));
      if (got.nz !== exp_hit.nz) report($sformatf("normal_z got %0d exp %0d", got.nz, exp_hit.nz));
    endtask
  endclass

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_WAIT  = 120;
  localparam int LONG_HOLD   = 400;

  logic              clk_i;
  logic              rst_ni;
  logic              psel, penable, pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [CFG_DW-1:0] pwdata;
  logic [CFG_DW-1:0] prdata;
  logic              pready;

  rosi_ray_if ray_if ();
  rosi_res_if res_if ();

  ray_obb_slab_intersect_top dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ray_i   (ray_if),
    .res_o   (res_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  hit_scoreboard sb = new();
  int  cycles;
  bit  long_hold;
  bit  send_burst;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // accepted rays and results
  always @(posedge clk_i) begin
    if (rst_ni && ray_if.valid && ray_if.ready)
      sb.note_ray({ray_if.origin_x, ray_if.origin_y, ray_if.origin_z, ray_if.dir_x,
                   ray_if.dir_y, ray_if.dir_z, ray_if.max_distance});
    if (rst_ni && res_if.valid && res_if.ready)
      sb.check_hit({res_if.hit_flag, res_if.hit_distance, res_if.point_x, res_if.point_y,
                    res_if.point_z, res_if.normal_x, res_if.normal_y, res_if.normal_z});
  end

  // result receiver: random stalls, stretches without stalls, one long hold on request
  initial begin
    int n;
    bit calm;
    calm = 1'b0;
    @(posedge rst_ni);
    forever begin
      if ($urandom_range(0, 15) == 0) calm = ~calm;
      if (long_hold) begin
        n = LONG_HOLD;
        long_hold = 1'b0;
      end else begin
        n = calm ? 0 : $urandom_range(0, 3);
      end
      if (n > 0) begin
        res_if.ready <= 1'b0;
        repeat (n) @(posedge clk_i);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk_i); while (!res_if.valid);
    end
  end

  task automatic send_ray(ray_t r);
    int gap;
    if ($urandom_range(0, 15) == 0) send_burst = ~send_burst;
    gap = send_burst ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      ray_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    ray_if.valid        <= 1'b1;
    ray_if.origin_x     <= r.ox;
    ray_if.origin_y     <= r.oy;
    ray_if.origin_z     <= r.oz;
    ray_if.dir_x        <= r.dx;
    ray_if.dir_y        <= r.dy;
    ray_if.dir_z        <= r.dz;
    ray_if.max_distance <= r.max_dist;
    do @(posedge clk_i); while (!ray_if.ready);
  endtask

  task automatic wait_drained();
    ray_if.valid <= 1'b0;
    while (sb.expected_hits.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [CFG_DW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_AW'(idx) << CFG_IDX_LSB;
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (idx <= REG_HALF) sb.box_reg[idx] = value & {{(CFG_DW - 3*POS_W){1'b0}}, {(3*POS_W){1'b1}}};
    else sb.box_reg[idx] = value & {{(CFG_DW - 3*AXIS_W){1'b0}}, {(3*AXIS_W){1'b1}}};
  endtask

  task automatic set_box(logic [CFG_DW-1:0] c, logic [CFG_DW-1:0] h,
                         logic [CFG_DW-1:0] r, logic [CFG_DW-1:0] u, logic [CFG_DW-1:0] f);
    wait_drained();
    write_reg(REG_CENTER, c);
    write_reg(REG_HALF, h);
    write_reg(REG_RIGHT, r);
    write_reg(REG_UP, u);
    write_reg(REG_FORWARD, f);
  endtask

  function automatic logic [CFG_DW-1:0] pack_pos(int x, int y, int z);
    logic [POS_W-1:0] a, b, c;
    a = POS_W'(x); b = POS_W'(y); c = POS_W'(z);
    return {4'($urandom_range(0, 15)), c, b, a};  // junk above the fields must be ignored
  endfunction

  function automatic logic [CFG_DW-1:0] pack_axis(int x, int y, int z);
    logic [AXIS_W-1:0] a, b, c;
    a = AXIS_W'(x); b = AXIS_W'(y); c = AXIS_W'(z);
    return {16'($urandom), c, b, a};
  endfunction

  function automatic int rand_signed(int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  // mostly rays aimed at or from inside the box, the rest unconstrained
  function automatic ray_t make_ray();
    ray_t r;
    int c [3], h [3], o [3];
    if ($urandom_range(0, 9) < 3) begin
      r = RAY_W'({$urandom, $urandom, $urandom, $urandom, $urandom});
      return r;
    end
    for (int i = 0; i < 3; i++) begin
      c[i] = int'($signed(sb.box_reg[REG_CENTER][i*POS_W +: POS_W]));
      h[i] = int'(sb.box_reg[REG_HALF][i*POS_W +: POS_W]);
      if (h[i] > 60000) h[i] = 60000;
      o[i] = ($urandom_range(0, 4) == 0) ? c[i] + rand_signed(h[i] / 2 + 1)
                                         : c[i] + rand_signed(120000);
    end
    r.ox = POS_W'(o[0]); r.oy = POS_W'(o[1]); r.oz = POS_W'(o[2]);
    r.dx = POS_W'(c[0] - o[0] + rand_signed(h[0] + 1));
    r.dy = POS_W'(c[1] - o[1] + rand_signed(h[1] + 1));
    r.dz = POS_W'(c[2] - o[2] + rand_signed(h[2] + 1));
    if ($urandom_range(0, 7) == 0) r.dx = '0;
    if ($urandom_range(0, 7) == 0) r.dy = '0;
    r.max_dist = ($urandom_range(0, 2) == 0) ? DIST_W'($urandom) : '1;
    return r;
  endfunction

  task automatic random_rays(int n);
    for (int i = 0; i < n; i++) send_ray(make_ray());
  endtask

  localparam int ONE = 16384;

  initial begin
    ray_t dr [$];
    cycles     = 0;
    long_hold  = 1'b0;
    send_burst = 1'b0;
    rst_ni  <= 1'b0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    ray_if.valid        <= 1'b0;
    ray_if.origin_x     <= '0;
    ray_if.origin_y     <= '0;
    ray_if.origin_z     <= '0;
    ray_if.dir_x        <= '0;
    ray_if.dir_y        <= '0;
    ray_if.dir_z        <= '0;
    ray_if.max_distance <= '0;
    res_if.ready        <= 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset box: zero axes make every slab parallel
    random_rays(10);

    // axis-aligned box at the origin, 10.0 half size
    set_box(pack_pos(0, 0, 0), pack_pos(2560, 2560, 2560),
            pack_axis(ONE, 0, 0), pack_axis(0, ONE, 0), pack_axis(0, 0, ONE));
    dr = '{
      '{20'sd0, 20'sd0, 20'sd0, 20'sd0, 20'sd0, 20'sd0, 19'd0},                  // zero ray inside
      '{20'sd5120, 20'sd0, 20'sd0, 20'sd0, 20'sd0, 20'sd0, '1},                  // zero dir outside
      '{-20'sd5120, 20'sd0, 20'sd0, 20'sd256, 20'sd0, 20'sd0, '1},               // hit -x face
      '{20'sd5120, 20'sd0, 20'sd0, -20'sd256, 20'sd0, 20'sd0, '1},               // hit +x face
      '{20'sd0, -20'sd5120, 20'sd0, 20'sd0, 20'sd9, 20'sd0, '1},
      '{20'sd0, 20'sd0, 20'sd5120, 20'sd0, 20'sd0, -20'sd1, '1},
      '{-20'sd5120, 20'sd5120, 20'sd0, 20'sd256, 20'sd0, 20'sd0, '1},            // parallel miss
      '{-20'sd5120, 20'sd100, 20'sd0, 20'sd256, 20'sd0, 20'sd0, '1},             // parallel inside
      '{-20'sd5120, 20'sd0, 20'sd0, 20'sd256, 20'sd0, 20'sd0, 19'd100},          // out of range
      '{-20'sd5120, 20'sd0, 20'sd0, 20'sd256, 20'sd0, 20'sd0, 19'd2560},         // exactly reaches
      '{-20'sd5120, 20'sd0, 20'sd0, -20'sd256, 20'sd0, 20'sd0, '1},              // points away
      '{20'sd100, 20'sd200, -20'sd300, 20'sd7, -20'sd3, 20'sd1, '1},             // origin inside
      '{20'sh7ffff, 20'sh7ffff, 20'sh7ffff, 20'sh80000, 20'sh80000, 20'sh80000, '1},
      '{20'sh80000, 20'sh80000, 20'sh80000, 20'sh7ffff, 20'sh7ffff, 20'sh7ffff, '1},
      '{20'sh80000, 20'sd0, 20'sd0, 20'sh7ffff, 20'sd0, 20'sd0, '1},
      '{20'sh7ffff, 20'sd0, 20'sd0, 20'sh80000, 20'sd1, 20'sd0, '1},
      '{-20'sd5120, -20'sd5120, -20'sd5120, 20'sd1, 20'sd1, 20'sd1, '1},         // corner
      '{-20'sd2560, 20'sd0, 20'sd0, 20'sd256, 20'sd0, 20'sd0, '1},               // on the face
      '{20'sh7ffff, 20'sh80000, 20'sh7ffff, 20'sh7ffff, 20'sh80000, 20'sh7ffff, 19'd0},
      '{20'sd0, 20'sd0, 20'sd0, 20'sd0, 20'sd0, 20'sd0, '1}
    };
    foreach (dr[i]) send_ray(dr[i]);
    random_rays(330);

    // box turned 30 degrees about z, receiver held off to fill the pipeline
    set_box(pack_pos(rand_signed(100000), rand_signed(100000), rand_signed(100000)),
            pack_pos($urandom_range(256, 40000), $urandom_range(256, 40000),
                     $urandom_range(256, 40000)),
            pack_axis(14189, 8192, 0), pack_axis(-8192, 14189, 0), pack_axis(0, 0, ONE));
    random_rays(100);
    long_hold = 1'b1;
    random_rays(230);

    // extremes: all-ones center, largest half sizes, most negative and largest axes
    set_box('1, '1, pack_axis(-32768, -32768, -32768), pack_axis(32767, 32767, 32767),
            pack_axis(-32768, 0, 32767));
    random_rays(150);
    // pause until the pipeline is empty
    ray_if.valid <= 1'b0;
    while (sb.expected_hits.size() != 0) @(posedge clk_i);
    random_rays(180);

    // arbitrary axes and box
    set_box({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
            {$urandom, $urandom}, {$urandom, $urandom});
    random_rays(330);

    // point-sized box, identity axes
    set_box(pack_pos(rand_signed(50000), rand_signed(50000), rand_signed(50000)), '0,
            pack_axis(ONE, 0, 0), pack_axis(0, ONE, 0), pack_axis(0, 0, ONE));
    random_rays(330);

    wait_drained();
    if (sb.errors == 0 && sb.expected_hits.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
